@@ rtl/lcdt_pkg.sv @@
package lcdt_pkg;

  // Fixed widths of the timing state and of the result fields.
  localparam int unsigned DOT_W   = 9;
  localparam int unsigned LINE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ENTRY_W = 6;

  // Line timing.
  localparam logic [DOT_W-1:0]   DOTS_PER_LINE    = 9'd456;
  localparam logic [DOT_W-1:0]   SEARCH_DOTS      = 9'd80;
  localparam logic [DOT_W-1:0]   TRANSFER_END_DOT = 9'd252;
  localparam logic [LINE_W:0]    TOTAL_LINES      = 9'd154;
  localparam logic [LINE_W-1:0]  VISIBLE_LINES    = 8'd144;
  localparam logic [ENTRY_W-1:0] SPRITE_ENTRIES   = 6'd40;

  // Display modes.
  localparam logic [MODE_W-1:0] MODE_HBLANK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSFER = 2'd3;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_DISPLAY_ENABLE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COMPARE_LINE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COMPARE_IRQ_EN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_IRQ_EN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HBLANK_IRQ_EN    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_VBLANK_STAT_EN   = 3'd5;

  // Register contents as seen by the timing core.
  typedef struct packed {
    logic              display_enable;
    logic [LINE_W-1:0] compare_line;
    logic              compare_irq_enable;
    logic              search_irq_enable;
    logic              hblank_irq_enable;
    logic              vblank_stat_enable;
  } lcdt_cfg_t;

  // One result item.
  typedef struct packed {
    logic [MODE_W-1:0]  lcd_mode;
    logic [LINE_W-1:0]  line_number;
    logic               line_match;
    logic               search_strobe;
    logic [ENTRY_W-1:0] search_entry;
    logic               sort_request;
    logic               draw_strobe;
    logic [LINE_W-1:0]  drawn_line;
    logic               vblank_irq;
    logic               stat_irq;
  } lcdt_result_t;

endpackage

@@ rtl/lcdt_regs.sv @@
module lcdt_regs
  import lcdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output lcdt_cfg_t   cfg_o
);

  lcdt_cfg_t             cfg_q;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg_o  = cfg_q;

  // Register writes on the access cycle of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_DISPLAY_ENABLE: cfg_q.display_enable     <= pwdata[0];
        REG_COMPARE_LINE:   cfg_q.compare_line       <= pwdata[LINE_W-1:0];
        REG_COMPARE_IRQ_EN: cfg_q.compare_irq_enable <= pwdata[0];
        REG_SEARCH_IRQ_EN:  cfg_q.search_irq_enable  <= pwdata[0];
        REG_HBLANK_IRQ_EN:  cfg_q.hblank_irq_enable  <= pwdata[0];
        REG_VBLANK_STAT_EN: cfg_q.vblank_stat_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    case (idx)
      REG_DISPLAY_ENABLE: prdata[0]          = cfg_q.display_enable;
      REG_COMPARE_LINE:   prdata[LINE_W-1:0] = cfg_q.compare_line;
      REG_COMPARE_IRQ_EN: prdata[0]          = cfg_q.compare_irq_enable;
      REG_SEARCH_IRQ_EN:  prdata[0]          = cfg_q.search_irq_enable;
      REG_HBLANK_IRQ_EN:  prdata[0]          = cfg_q.hblank_irq_enable;
      REG_VBLANK_STAT_EN: prdata[0]          = cfg_q.vblank_stat_enable;
      default:            prdata             = '0;
    endcase
  end

endmodule

@@ rtl/lcdt_core.sv @@
module lcdt_core
  import lcdt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         tick_i,
  input  lcdt_cfg_t    cfg_i,
  output lcdt_result_t res_o
);

  logic [DOT_W-1:0]   dot_q, dot_d;
  logic [LINE_W-1:0]  line_q, line_d;
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [ENTRY_W-1:0] sidx_q, sidx_d;
  logic               match_q, match_d;

  logic               adv;
  logic [DOT_W-1:0]   dot_inc;
  logic [LINE_W:0]    line_inc;
  logic               entry_irq;

  assign adv = tick_i && cfg_i.display_enable;

  // Next timing state and the strobes of this tick.
  always_comb begin
    dot_d     = dot_q;
    line_d    = line_q;
    mode_d    = mode_q;
    sidx_d    = sidx_q;
    match_d   = match_q;
    entry_irq = 1'b0;
    dot_inc   = dot_q + 9'd1;
    line_inc  = {1'b0, line_q} + 9'd1;
    res_o     = '0;

    if (adv) begin
      // Mode by position within a visible line.
      if (line_q < VISIBLE_LINES) begin
        if (dot_q < SEARCH_DOTS) begin
          mode_d = MODE_SEARCH;
          if (dot_q[0]) begin
            if (sidx_q < SPRITE_ENTRIES) begin
              res_o.search_strobe = 1'b1;
              res_o.search_entry  = sidx_q;
              sidx_d              = sidx_q + 6'd1;
            end
            if (sidx_d >= SPRITE_ENTRIES) begin
              res_o.sort_request = 1'b1;
            end
          end
        end else if (dot_q < TRANSFER_END_DOT) begin
          mode_d = MODE_TRANSFER;
        end else begin
          mode_d = MODE_HBLANK;
        end
      end

      // End of line: advance the line and re-check the compare.
      dot_d = dot_inc;
      if (dot_inc >= DOTS_PER_LINE) begin
        dot_d = '0;
        if (line_q < VISIBLE_LINES) begin
          res_o.draw_strobe = 1'b1;
          res_o.drawn_line  = line_q;
        end
        line_d = (line_inc >= TOTAL_LINES) ? '0 : line_inc[LINE_W-1:0];
        match_d = (line_d == cfg_i.compare_line);
        if (match_d && cfg_i.compare_irq_enable) begin
          res_o.stat_irq = 1'b1;
        end
        if (line_d == VISIBLE_LINES) begin
          res_o.vblank_irq = 1'b1;
          mode_d           = MODE_VBLANK;
          entry_irq        = cfg_i.vblank_stat_enable;
        end
      end

      // Mode entry interrupts only on an actual mode change.
      if (mode_d != mode_q) begin
        if (mode_d == MODE_SEARCH) begin
          entry_irq = entry_irq || cfg_i.search_irq_enable;
          sidx_d    = '0;
        end else if (mode_d == MODE_HBLANK) begin
          entry_irq = entry_irq || cfg_i.hblank_irq_enable;
        end
        if (entry_irq) begin
          res_o.stat_irq = 1'b1;
        end
      end
    end

    res_o.lcd_mode    = mode_d;
    res_o.line_number = line_d;
    res_o.line_match  = match_d;
  end

  // Timing state advances only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q   <= '0;
      line_q  <= '0;
      mode_q  <= MODE_HBLANK;
      sidx_q  <= '0;
      match_q <= 1'b0;
    end else if (step_i) begin
      dot_q   <= dot_d;
      line_q  <= line_d;
      mode_q  <= mode_d;
      sidx_q  <= sidx_d;
      match_q <= match_d;
    end
  end

  // A sprite entry is only examined during sprite search.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.search_strobe |-> (res_o.lcd_mode == MODE_SEARCH))
    else $error("search strobe outside sprite search");

  // Vertical blank request comes with the first invisible line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.vblank_irq |-> (res_o.lcd_mode == MODE_VBLANK &&
                          res_o.line_number == VISIBLE_LINES))
    else $error("vblank request without vblank entry");

  // The line counter stays inside the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, line_q} < TOTAL_LINES)
    else $error("line counter beyond frame");

  // A frozen tick changes no state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !adv) |=> ($stable(dot_q) && $stable(line_q) && $stable(mode_q)))
    else $error("timing moved on an idle tick");

endmodule

@@ rtl/lcd_line_mode_timing.sv @@
// LCD line and mode timing controller.
// Each transaction on the slave stream is one dot tick (tdata bit 0). While
// display_enable is set, a tick of 1 advances the dot and line counters; a
// tick of 0, or a disabled display, only reports the current status.
// Every input transaction produces exactly one result transaction on the
// master stream carrying mode, line, compare flag, sprite search and sort
// strobes, draw strobe and the vblank and status interrupt requests.
// An accepted input is held in the input register, processed by the timing
// core and captured in the result register, which offers it downstream.
// Throughput: one item per cycle while the receiver accepts results; the
// timing core updates its state as each item enters the result register.
// When the receiver stalls the result register holds, the input register
// takes one more item, and then s_axis_tready_o drops until space frees.
// Reset clears all counters to line 0, dot 0, hblank, and clears every
// configuration register, so the display starts disabled. The user must
// write registers at APB byte address 4*index only while idle, unenforced.
module lcd_line_mode_timing
  import lcdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields: dot_tick [0], zero fill [7:1].
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Fields: lcd_mode [1:0], line_number [9:2], line_match [10],
  // search_strobe [11], search_entry [17:12], sort_request [18],
  // draw_strobe [19], drawn_line [27:20], vblank_irq [28], stat_irq [29],
  // zero fill [31:30].
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  lcdt_cfg_t    cfg;
  lcdt_result_t res;
  lcdt_result_t out_q;
  logic         in_valid_q;
  logic         in_tick_q;
  logic         out_valid_q;
  logic         fire;
  logic         in_take;

  lcdt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (fire),
    .tick_i (in_tick_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Process the held tick whenever the result register is free or draining.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_tick_q <= s_axis_tdata_i[0];
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00,
                            out_q.stat_irq,
                            out_q.vblank_irq,
                            out_q.drawn_line,
                            out_q.draw_strobe,
                            out_q.sort_request,
                            out_q.search_entry,
                            out_q.search_strobe,
                            out_q.line_match,
                            out_q.line_number,
                            out_q.lcd_mode};

endmodule
